### rtl/sma_pkg.sv
`default_nettype none

package sma_pkg;

  localparam int SAMPLE_W = 16;
  localparam int STRIDE_W = 3;
  localparam int HALF_W   = 4;
  localparam int CFG_W    = 4;
  localparam int CFG_IDX_W = 1;

  localparam int MAX_STRIDE_DEF = 4;
  localparam int MAX_HALF_DEF   = 8;

  localparam logic [STRIDE_W-1:0] STRIDE_RST = 3'd1;
  localparam logic [HALF_W-1:0]   HALF_RST   = 4'd1;

  localparam int JOB_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRIDE = 1'b0,
    CFG_HALF   = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SETUP,
    B_ACC,
    B_DRAIN,
    B_PREP,
    B_DIV,
    B_PUSH
  } back_state_e;

endpackage

`default_nettype wire

### rtl/strided_moving_average.sv
// Centred moving average over an interleaved stream of up to MAX_STRIDE components.
// Input channel: a sample word with its last flag is taken when push_i is high and
// full_o is low. Result channel: the oldest result sits on average_o/last_res_o while
// empty_o is low and is taken when pop_i is high. Registers are written through
// cfg_we_i/cfg_idx_i/cfg_wdata_i (index 0 stride, index 1 half window); the user must
// write them only while no word is in flight, as the block does not enforce it. The
// first half_window*stride words of a stream give no result; each later word gives
// one, and the word flagged last gives every remaining result, the final one flagged.
// A front stage stores each word in a ring buffer RAM and queues a job; the back
// stage reads the 2h+1 window slots one per RAM read cycle, then runs a bit-serial
// divider. Each result passes through queue hand-over, setup, the window reads, a
// drain of the last read, division and result push. Further results of a flushing
// word skip the queue. Words that give no result are taken one per cycle while the
// two-entry job queue has room. A stalled receiver fills the result queue, which
// halts the back stage and then the front. Reset sets stride and half window to 1,
// empties both queues and starts a new stream; the RAM is not cleared, as only slots
// of the current stream are read.
`default_nettype none

module strided_moving_average import sma_pkg::*; #(
  parameter int MAX_STRIDE = MAX_STRIDE_DEF,
  parameter int MAX_HALF   = MAX_HALF_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic       [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic       [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                       push_i,
  output logic                            full_o,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic                       last_i,
  output logic                            empty_o,
  input  wire logic                       pop_i,
  output logic signed     [SAMPLE_W-1:0]  average_o,
  output logic                            last_res_o
);

  localparam int STORE_DEPTH = 2 * MAX_HALF * MAX_STRIDE + 1;
  // ring is well over twice the window so queued jobs never see overwritten slots
  localparam int AW    = $clog2(STORE_DEPTH) + 2;
  localparam int N_W   = $clog2(STORE_DEPTH);
  localparam int S_W   = $clog2(MAX_STRIDE + 1);
  localparam int H_W   = $clog2(MAX_HALF + 1);
  localparam int L_W   = $clog2(MAX_HALF * MAX_STRIDE + 1);
  localparam int JOB_W = AW + N_W + S_W + H_W + 2 * L_W + 1;
  localparam int RES_W = SAMPLE_W + 1;

  logic               job_push, job_full, job_pop, job_empty;
  logic [JOB_W-1:0]   job_wdata, job_rdata;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;
  logic               res_push, res_full;
  logic [SAMPLE_W-1:0] res_average;
  logic               res_last;
  logic [RES_W-1:0]   res_rdata;

  assign full_o = job_full;

  sma_front #(
    .MAX_STRIDE(MAX_STRIDE),
    .MAX_HALF  (MAX_HALF)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_i     (push_i),
    .sample_i   (sample_i),
    .last_i     (last_i),
    .job_full_i (job_full),
    .job_push_o (job_push),
    .job_o      (job_wdata),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata)
  );

  sma_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(2 ** AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  sma_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(JOB_DEPTH)
  ) u_job_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .wdata_i(job_wdata),
    .full_o (job_full),
    .pop_i  (job_pop),
    .rdata_o(job_rdata),
    .empty_o(job_empty)
  );

  sma_back #(
    .MAX_STRIDE(MAX_STRIDE),
    .MAX_HALF  (MAX_HALF)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (job_rdata),
    .job_valid_i  (!job_empty),
    .job_pop_o    (job_pop),
    .rd_en_o      (ram_re),
    .rd_addr_o    (ram_raddr),
    .rd_data_i    (ram_rdata),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_average_o(res_average),
    .res_last_o   (res_last)
  );

  sma_fifo #(
    .WIDTH(RES_W),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i({res_last, res_average}),
    .full_o (res_full),
    .pop_i  (pop_i),
    .rdata_o(res_rdata),
    .empty_o(empty_o)
  );

  assign average_o  = res_rdata[SAMPLE_W-1:0];
  assign last_res_o = res_rdata[SAMPLE_W];

endmodule

`default_nettype wire

### rtl/sma_ram.sv
`default_nettype none

module sma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/sma_fifo.sv
`default_nettype none

module sma_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

### rtl/sma_front.sv
`default_nettype none

module sma_front import sma_pkg::*; #(
  parameter int MAX_STRIDE = MAX_STRIDE_DEF,
  parameter int MAX_HALF   = MAX_HALF_DEF,
  localparam int STORE_DEPTH = 2 * MAX_HALF * MAX_STRIDE + 1,
  localparam int AW     = $clog2(STORE_DEPTH) + 2,
  localparam int N_W    = $clog2(STORE_DEPTH),
  localparam int SEEN_W = $clog2(STORE_DEPTH + 1),
  localparam int S_W    = $clog2(MAX_STRIDE + 1),
  localparam int H_W    = $clog2(MAX_HALF + 1),
  localparam int L_W    = $clog2(MAX_HALF * MAX_STRIDE + 1),
  localparam int JOB_W  = AW + N_W + S_W + H_W + 2 * L_W + 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic       [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic       [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                       push_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic                       last_i,
  input  wire logic                       job_full_i,
  output logic                            job_push_o,
  output logic            [JOB_W-1:0]     job_o,
  output logic                            ram_we_o,
  output logic            [AW-1:0]        ram_waddr_o,
  output logic            [SAMPLE_W-1:0]  ram_wdata_o
);

  typedef struct packed {
    logic [AW-1:0]  ptr;
    logic [N_W-1:0] n;
    logic [S_W-1:0] s;
    logic [H_W-1:0] h;
    logic [L_W-1:0] l;
    logic [L_W-1:0] dc;
    logic           flush;
  } job_t;

  logic [STRIDE_W-1:0] stride_q;
  logic [HALF_W-1:0]   half_q;
  logic [SEEN_W-1:0]   seen_q, seen_d, seen_inc;
  logic [AW-1:0]       wptr_q, wptr_d;

  logic [S_W-1:0] s_eff;
  logic [H_W-1:0] h_eff;
  logic [L_W-1:0] l_eff;
  logic [N_W-1:0] n_cur;
  logic           accept;
  job_t           job;

  assign accept = push_i && !job_full_i;

  always_comb begin
    if (stride_q == '0) begin
      s_eff = S_W'(1);
    end else if (32'(stride_q) > MAX_STRIDE) begin
      s_eff = S_W'(MAX_STRIDE);
    end else begin
      s_eff = S_W'(stride_q);
    end
    if (32'(half_q) > MAX_HALF) begin
      h_eff = H_W'(MAX_HALF);
    end else begin
      h_eff = H_W'(half_q);
    end
    l_eff = L_W'(L_W'(h_eff) * L_W'(s_eff));
  end

  // count saturates once the store holds a full window
  assign seen_inc = (seen_q < SEEN_W'(STORE_DEPTH)) ? seen_q + 1'b1 : seen_q;
  assign n_cur    = N_W'(seen_inc - 1'b1);

  always_comb begin
    job.ptr   = wptr_q;
    job.n     = n_cur;
    job.s     = s_eff;
    job.h     = h_eff;
    job.l     = l_eff;
    job.flush = last_i;
    if (last_i && (n_cur < N_W'(l_eff))) begin
      job.dc = L_W'(n_cur);
    end else begin
      job.dc = l_eff;
    end
  end

  assign job_o       = job;
  assign job_push_o  = accept && (last_i || (n_cur >= N_W'(l_eff)));
  assign ram_we_o    = accept;
  assign ram_waddr_o = wptr_q;
  assign ram_wdata_o = sample_i;

  always_comb begin
    seen_d = seen_q;
    wptr_d = wptr_q;
    if (accept) begin
      wptr_d = wptr_q + 1'b1;
      seen_d = last_i ? '0 : seen_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= STRIDE_RST;
      half_q   <= HALF_RST;
      seen_q   <= '0;
      wptr_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_STRIDE: stride_q <= cfg_wdata_i[STRIDE_W-1:0];
          CFG_HALF:   half_q   <= cfg_wdata_i[HALF_W-1:0];
          default:    ;
        endcase
      end
      seen_q <= seen_d;
      wptr_q <= wptr_d;
    end
  end

endmodule

`default_nettype wire

### rtl/sma_back.sv
`default_nettype none

module sma_back import sma_pkg::*; #(
  parameter int MAX_STRIDE = MAX_STRIDE_DEF,
  parameter int MAX_HALF   = MAX_HALF_DEF,
  localparam int STORE_DEPTH = 2 * MAX_HALF * MAX_STRIDE + 1,
  localparam int AW    = $clog2(STORE_DEPTH) + 2,
  localparam int N_W   = $clog2(STORE_DEPTH),
  localparam int S_W   = $clog2(MAX_STRIDE + 1),
  localparam int H_W   = $clog2(MAX_HALF + 1),
  localparam int L_W   = $clog2(MAX_HALF * MAX_STRIDE + 1),
  localparam int JOB_W = AW + N_W + S_W + H_W + 2 * L_W + 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [JOB_W-1:0]     job_i,
  input  wire logic                 job_valid_i,
  output logic                      job_pop_o,
  output logic                      rd_en_o,
  output logic      [AW-1:0]        rd_addr_o,
  input  wire logic [SAMPLE_W-1:0]  rd_data_i,
  input  wire logic                 res_full_i,
  output logic                      res_push_o,
  output logic      [SAMPLE_W-1:0]  res_average_o,
  output logic                      res_last_o
);

  typedef struct packed {
    logic [AW-1:0]  ptr;
    logic [N_W-1:0] n;
    logic [S_W-1:0] s;
    logic [H_W-1:0] h;
    logic [L_W-1:0] l;
    logic [L_W-1:0] dc;
    logic           flush;
  } job_t;

  localparam int D_W   = $clog2(STORE_DEPTH) + 1;  // signed offset back from newest
  localparam int K_W   = $clog2(2 * MAX_HALF + 1);
  localparam int CNT_W = $clog2(2 * MAX_HALF + 2);
  localparam int DEN_W = CNT_W + 1;
  localparam int ACC_W = SAMPLE_W + $clog2(2 * MAX_HALF + 1);
  localparam int NUM_W = ACC_W + 1;
  localparam int BIT_W = $clog2(NUM_W);

  back_state_e state_q, state_d;

  job_t             job_in, job_q;
  logic [L_W-1:0]   dc_q;
  logic [D_W-1:0]   d_q;
  logic [K_W-1:0]   k_q;
  logic             rvld_q;
  logic [ACC_W-1:0] acc_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [BIT_W-1:0] bit_q;
  logic             neg_q;

  logic             issue_ok;
  logic [K_W-1:0]   last_k;
  logic [ACC_W-1:0] acc_add;
  logic [ACC_W-1:0] mag;
  logic [NUM_W-1:0] num_init;
  logic [DEN_W:0]   rem_sh;
  logic             q_bit;
  logic [DEN_W-1:0] rem_nx;
  logic [NUM_W-1:0] q_signed;
  logic             more;

  assign job_in = job_t'(job_i);

  // window slot exists only between the newest sample and the stream start
  assign issue_ok = !d_q[D_W-1] && (d_q[D_W-2:0] <= job_q.n);
  assign last_k   = K_W'({job_q.h, 1'b0});
  assign acc_add  = acc_q + {{(ACC_W - SAMPLE_W){rd_data_i[SAMPLE_W-1]}}, rd_data_i};
  assign more     = job_q.flush && (dc_q != '0);

  // rounding: q = (2|sum| + cnt) / (2 cnt)
  assign mag      = acc_q[ACC_W-1] ? (~acc_q + 1'b1) : acc_q;
  assign num_init = {mag, 1'b0} + NUM_W'(cnt_q);

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, den_q});
  assign rem_nx = q_bit ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);

  assign q_signed = neg_q ? (~num_q + 1'b1) : num_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (job_valid_i) state_d = B_SETUP;
      B_SETUP: state_d = B_ACC;
      B_ACC:   if (k_q == last_k) state_d = B_DRAIN;
      B_DRAIN: state_d = B_PREP;
      B_PREP:  state_d = B_DIV;
      B_DIV:   if (bit_q == BIT_W'(NUM_W - 1)) state_d = B_PUSH;
      B_PUSH: begin
        if (!res_full_i) state_d = more ? B_SETUP : B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    job_pop_o  = 1'b0;
    rd_en_o    = 1'b0;
    res_push_o = 1'b0;
    case (state_q)
      B_IDLE:  job_pop_o  = job_valid_i;
      B_ACC:   rd_en_o    = 1'b1;
      B_PUSH:  res_push_o = !res_full_i;
      default: ;
    endcase
  end

  assign rd_addr_o     = job_q.ptr - AW'(d_q);
  assign res_average_o = q_signed[SAMPLE_W-1:0];
  assign res_last_o    = job_q.flush && (dc_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (job_valid_i) begin
          job_q <= job_in;
          dc_q  <= job_in.dc;
        end
      end
      B_SETUP: begin
        d_q    <= D_W'(dc_q) + D_W'(job_q.l);
        k_q    <= '0;
        acc_q  <= '0;
        cnt_q  <= '0;
        rvld_q <= 1'b0;
      end
      B_ACC: begin
        // read data arrives in the cycle after its address
        rvld_q <= issue_ok;
        d_q    <= d_q - D_W'(job_q.s);
        k_q    <= k_q + 1'b1;
        if (rvld_q) begin
          acc_q <= acc_add;
          cnt_q <= cnt_q + 1'b1;
        end
      end
      B_DRAIN: begin
        if (rvld_q) begin
          acc_q <= acc_add;
          cnt_q <= cnt_q + 1'b1;
        end
      end
      B_PREP: begin
        num_q <= num_init;
        den_q <= {cnt_q, 1'b0};
        rem_q <= '0;
        bit_q <= '0;
        neg_q <= acc_q[ACC_W-1];
      end
      B_DIV: begin
        rem_q <= rem_nx;
        num_q <= {num_q[NUM_W-2:0], q_bit};
        bit_q <= bit_q + 1'b1;
      end
      B_PUSH: begin
        if (!res_full_i) dc_q <= dc_q - 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### verif/tb_strided_moving_average.sv
module tb_strided_moving_average;
  timeunit 1ns;
  timeprecision 1ps;

  import sma_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int HIST_DEPTH   = 2 * MAX_HALF_DEF * MAX_STRIDE_DEF + 1;
  localparam int SETTLE_CYCLES = 150;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int RANDOM_WORDS = 188;
  localparam int IDLE_PCT     = 12;

  typedef enum logic {ROW_REG, ROW_WORD} row_kind_e;

  typedef struct {
    row_kind_e                   kind;
    cfg_reg_e                    idx;
    logic [CFG_W-1:0]            val;
    logic signed [SAMPLE_W-1:0]  smp;
    logic                        lst;
    bit                          known;
    logic signed [SAMPLE_W-1:0]  known_avg;
    logic                        known_last;
  } stim_row_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] avg;
    logic                       lst;
  } average_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  cfg_reg_e                   cfg_idx_i   = CFG_STRIDE;
  logic [CFG_W-1:0]           cfg_wdata_i = '0;
  logic                       push_i      = 1'b0;
  logic                       full_o;
  logic signed [SAMPLE_W-1:0] sample_i    = '0;
  logic                       last_i      = 1'b0;
  logic                       empty_o;
  logic                       pop_i       = 1'b0;
  logic signed [SAMPLE_W-1:0] average_o;
  logic                       last_res_o;

  // expected value typed into the table, travels with the word
  bit                         tag_known   = 1'b0;
  logic signed [SAMPLE_W-1:0] tag_avg     = '0;
  logic                       tag_last    = 1'b0;

  bit                         calm        = 1'b0;
  bit                         failed      = 1'b0;
  int unsigned                cycles      = 0;

  // predictor state
  logic [STRIDE_W-1:0]        stride_cfg  = STRIDE_RST;
  logic [HALF_W-1:0]          half_cfg    = HALF_RST;
  logic signed [SAMPLE_W-1:0] recent_words [HIST_DEPTH];
  int                         stream_fill = 0;
  average_t                   averages_due[$];

  stim_row_t                  plan_q[$];

  strided_moving_average dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push_i),
    .full_o      (full_o),
    .sample_i    (sample_i),
    .last_i      (last_i),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .average_o   (average_o),
    .last_res_o  (last_res_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // rounded mean of the in-stream words around the centre dc slots back
  function automatic int window_average(int dc, int n, int s, int h);
    int sum;
    int cnt;
    int d;
    int m;
    int mag;
    int q;
    sum = 0;
    cnt = 0;
    for (m = -h; m <= h; m++) begin
      d = dc - m * s;
      if (d >= 0 && d <= n && d < HIST_DEPTH) begin
        sum += recent_words[d];
        cnt++;
      end
    end
    if (cnt == 0) return 0;
    mag = (sum < 0) ? -sum : sum;
    q = (2 * mag + cnt) / (2 * cnt);
    return (sum < 0) ? -q : q;
  endfunction

  function automatic int predict_averages(logic signed [SAMPLE_W-1:0] smp, logic lst);
    int       s;
    int       h;
    int       span;
    int       n;
    int       first;
    int       cnt;
    int       dc;
    average_t r;
    s = stride_cfg;
    h = half_cfg;
    if (s < 1) s = 1;
    if (s > MAX_STRIDE_DEF) s = MAX_STRIDE_DEF;
    if (h > MAX_HALF_DEF) h = MAX_HALF_DEF;
    span = h * s;
    for (int i = HIST_DEPTH - 1; i > 0; i--) recent_words[i] = recent_words[i-1];
    recent_words[0] = smp;
    if (stream_fill < HIST_DEPTH) stream_fill++;
    n = stream_fill - 1;
    cnt = 0;
    if (!lst) begin
      if (n >= span) begin
        r.avg = SAMPLE_W'(window_average(span, n, s, h));
        r.lst = 1'b0;
        averages_due.push_back(r);
        cnt = 1;
      end
    end else begin
      first = (n < span) ? n : span;
      for (dc = first; dc >= 0; dc--) begin
        r.avg = SAMPLE_W'(window_average(dc, n, s, h));
        r.lst = (dc == 0);
        averages_due.push_back(r);
        cnt++;
      end
      stream_fill = 0;
    end
    return cnt;
  endfunction

  always @(posedge clk_i) begin : track
    average_t due;
    int       made;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_STRIDE) stride_cfg = cfg_wdata_i[STRIDE_W-1:0];
        else half_cfg = cfg_wdata_i[HALF_W-1:0];
      end
      if (push_i && !full_o) begin
        made = predict_averages(sample_i, last_i);
        if (tag_known && made > 0) begin
          due.avg = tag_avg;
          due.lst = tag_last;
          averages_due[averages_due.size()-1] = due;
        end
      end
      if (pop_i && !empty_o) begin
        if (averages_due.size() == 0) begin
          $error("unexpected word: average %0d last_res %0b", average_o, last_res_o);
          failed = 1'b1;
        end else begin
          due = averages_due.pop_front();
          if (average_o !== due.avg) begin
            $error("average: expected %0d, got %0d", due.avg, average_o);
            failed = 1'b1;
          end
          if (last_res_o !== due.lst) begin
            $error("last_res: expected %0b, got %0b", due.lst, last_res_o);
            failed = 1'b1;
          end
        end
      end
    end
  end

  always @(posedge clk_i) pop_i <= calm || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void plan_reg(cfg_reg_e idx, int val);
    stim_row_t r;
    r = '{kind: ROW_REG, idx: idx, val: CFG_W'(val), smp: '0, lst: 1'b0,
          known: 1'b0, known_avg: '0, known_last: 1'b0};
    plan_q.push_back(r);
  endfunction

  function automatic void plan_word(int smp, bit lst);
    stim_row_t r;
    r = '{kind: ROW_WORD, idx: CFG_STRIDE, val: '0, smp: SAMPLE_W'(smp), lst: lst,
          known: 1'b0, known_avg: '0, known_last: 1'b0};
    plan_q.push_back(r);
  endfunction

  function automatic void plan_known(int smp, bit lst, int avg, bit avg_last);
    stim_row_t r;
    r = '{kind: ROW_WORD, idx: CFG_STRIDE, val: '0, smp: SAMPLE_W'(smp), lst: lst,
          known: 1'b1, known_avg: SAMPLE_W'(avg), known_last: avg_last};
    plan_q.push_back(r);
  endfunction

  // drop push, drain every expected word, then let the back stage go quiet
  task automatic settle();
    push_i <= 1'b0;
    do @(posedge clk_i); while (averages_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_W'(val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic push_word(logic signed [SAMPLE_W-1:0] smp, logic lst, bit known,
                           logic signed [SAMPLE_W-1:0] avg, logic avg_last);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      push_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    push_i    <= 1'b1;
    sample_i  <= smp;
    last_i    <= lst;
    tag_known <= known;
    tag_avg   <= avg;
    tag_last  <= avg_last;
    do @(posedge clk_i); while (full_o);
  endtask

  initial begin : stimulus
    int                         sent;
    int                         len;
    bit                         shift_half;
    logic signed [SAMPLE_W-1:0] word_val;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, stride 1 and half window 1
    plan_word(100, 1'b0);
    plan_known(300, 1'b1, 200, 1'b1);
    plan_word(-1, 1'b0);
    plan_known(-2, 1'b1, -2, 1'b1);   // -1.5 rounds away from zero
    // no window: each word comes straight back
    plan_reg(CFG_HALF, 0);
    plan_known(32767, 1'b0, 32767, 1'b0);
    plan_known(-32768, 1'b0, -32768, 1'b0);
    plan_known(0, 1'b1, 0, 1'b1);
    // zero stride and oversized half window; stream ends before the lag fills
    plan_reg(CFG_STRIDE, 0);
    plan_reg(CFG_HALF, 15);
    plan_word(32767, 1'b0);
    plan_word(32767, 1'b0);
    plan_word(-32768, 1'b1);
    // oversized stride, window changed part way through a stream
    plan_reg(CFG_STRIDE, 7);
    plan_reg(CFG_HALF, 2);
    for (int i = 0; i < 10; i++) plan_word(i * 1000 - 4000, 1'b0);
    plan_reg(CFG_HALF, 1);
    plan_word(1234, 1'b0);
    plan_word(-5, 1'b1);

    foreach (plan_q[i]) begin
      if (plan_q[i].kind == ROW_REG) begin
        settle();
        write_reg(plan_q[i].idx, plan_q[i].val);
      end else begin
        push_word(plan_q[i].smp, plan_q[i].lst, plan_q[i].known,
                  plan_q[i].known_avg, plan_q[i].known_last);
      end
    end

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      calm <= (sent >= 80 && sent < 140);
      if ($urandom_range(1) == 1) begin
        settle();
        write_reg(CFG_STRIDE, $urandom_range(15));
        write_reg(CFG_HALF, ($urandom_range(3) == 0) ? $urandom_range(15)
                                                     : $urandom_range(3));
      end
      // now and then a stream long enough to fill the whole history
      len = ($urandom_range(7) == 0) ? $urandom_range(66, 90) : $urandom_range(1, 24);
      if (len > RANDOM_WORDS - sent) len = RANDOM_WORDS - sent;
      shift_half = ($urandom_range(5) == 0) && len > 3;
      for (int k = 0; k < len; k++) begin
        if (shift_half && k == len / 2) begin
          settle();
          write_reg(CFG_HALF, $urandom_range(4));
        end
        if ($urandom_range(7) == 0)
          word_val = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        else
          word_val = SAMPLE_W'($urandom());
        push_word(word_val, k == len - 1, 1'b0, '0, 1'b0);
        sent++;
      end
    end

    calm <= 1'b0;
    settle();
    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
